### design/light_gate_sequencer_defines.svh
// Assertion macros shared by the light gate sequencer RTL.
// Files that hold assertions include this header; it depends on nothing else.
`ifndef LIGHT_GATE_SEQUENCER_DEFINES_SVH
`define LIGHT_GATE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define LGS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("light_gate_sequencer: assertion failed");
// Implication whose consequent is checked in the cycle after its antecedent.
`define LGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("light_gate_sequencer: assertion failed");
`else
`define LGS_ASSERT(lbl, prop)
`define LGS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### design/lgs_pkg.sv
// Types and constants of the light gate sequencer: command and report codes,
// register indexes and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

  localparam int CNT_W       = 10;
  localparam int BYTE_W      = 8;
  localparam int PHASE_W     = 2;
  localparam int STEP_W      = 2;
  localparam int CFG_INDEX_W = 2;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [STEP_W-1:0]  step_t;

  // Received commands.
  localparam byte_t CMD_NONE       = 8'h00;
  localparam byte_t CMD_TOGGLE_ONE = 8'h6D;  // 'm'
  localparam byte_t CMD_TOGGLE_TWO = 8'h6E;  // 'n'
  localparam byte_t CMD_CHECK      = 8'h63;  // 'c'
  localparam byte_t CMD_ARM        = 8'h72;  // 'r'

  // Report bytes.
  localparam byte_t REP_NONE   = 8'h00;
  localparam byte_t REP_START  = 8'h73;  // 's'
  localparam byte_t REP_FINISH = 8'h66;  // 'f'
  localparam byte_t REP_PASS   = 8'h31;  // '1'
  localparam byte_t REP_FAIL   = 8'h30;  // '0'

  // Gate phase codes, as seen on the gate_phase port.
  localparam phase_t PHASE_INACTIVE = 2'd0;
  localparam phase_t PHASE_ARMED    = 2'd1;
  localparam phase_t PHASE_TIMING   = 2'd2;

  // Probe step codes.
  localparam step_t PROBE_IDLE = 2'd0;
  localparam step_t PROBE_ONE  = 2'd1;
  localparam step_t PROBE_TWO  = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_W-1:0] CFG_PROBE_TIMEOUT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOOT_DELAY    = 2'd1;
  localparam count_t PROBE_TIMEOUT_RESET = 10'd100;
  localparam count_t BOOT_DELAY_RESET    = 10'd10;

  typedef struct packed {
    count_t probe_timeout;
    count_t boot_delay;
  } cfg_t;

  typedef struct packed {
    logic  rx_valid;
    byte_t rx_byte;
    logic  sensor_one;
    logic  sensor_two;
  } item_t;

  typedef struct packed {
    phase_t phase;
    logic   laser_one;
    logic   laser_two;
    byte_t  mailbox;
    step_t  probe_step;
    count_t probe_count;
    count_t settle_count;
  } state_t;

  typedef struct packed {
    logic   laser_one_on;
    logic   laser_two_on;
    logic   tx_valid;
    byte_t  tx_byte;
    phase_t gate_phase;
  } result_t;

endpackage

`default_nettype wire

### design/lgs_cfg.sv
// Configuration registers of the light gate sequencer.
// Depends on lgs_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module lgs_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [lgs_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire lgs_pkg::count_t                 wr_data,
  output lgs_pkg::cfg_t                        cfg
);

  lgs_pkg::count_t probe_timeout;
  lgs_pkg::count_t boot_delay;

  // Writes to indexes past the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_timeout <= lgs_pkg::PROBE_TIMEOUT_RESET;
      boot_delay    <= lgs_pkg::BOOT_DELAY_RESET;
    end else if (wr_en) begin
      if (wr_index == lgs_pkg::CFG_PROBE_TIMEOUT) begin
        probe_timeout <= wr_data;
      end
      if (wr_index == lgs_pkg::CFG_BOOT_DELAY) begin
        boot_delay <= wr_data;
      end
    end
  end

  assign cfg.probe_timeout = probe_timeout;
  assign cfg.boot_delay    = boot_delay;

endmodule

`default_nettype wire

### design/lgs_step.sv
// Next-state and result logic for one tick of the light gate sequencer.
// Purely combinational; depends on lgs_pkg for its structs and codes.
`timescale 1ns / 1ps
`default_nettype none

module lgs_step (
  input  wire lgs_pkg::state_t  state,
  input  wire lgs_pkg::item_t   item,
  input  wire lgs_pkg::cfg_t    cfg,
  output lgs_pkg::state_t       state_next,
  output lgs_pkg::result_t      result
);

  always_comb begin
    lgs_pkg::state_t s;
    lgs_pkg::count_t cnt_inc;
    logic            level;
    logic            done;
    logic            stop;
    logic            send;
    lgs_pkg::byte_t  rep;

    s       = state;
    send    = 1'b0;
    rep     = lgs_pkg::REP_NONE;
    done    = 1'b0;
    stop    = 1'b0;
    cnt_inc = state.probe_count + 10'd1;
    level   = (state.probe_step == lgs_pkg::PROBE_ONE) ? item.sensor_one : item.sensor_two;

    if (item.rx_valid) begin
      s.mailbox = item.rx_byte;
    end

    if (state.settle_count != '0) begin
      s.settle_count = state.settle_count - 10'd1;
    end else if (state.probe_step != lgs_pkg::PROBE_IDLE) begin
      // A zero timeout fails at once without looking at the sensor.
      if (cfg.probe_timeout == '0) begin
        rep  = lgs_pkg::REP_FAIL;
        done = 1'b1;
      end else if (!level) begin
        rep  = lgs_pkg::REP_PASS;
        done = 1'b1;
      end else begin
        s.probe_count = cnt_inc;
        if (cnt_inc >= cfg.probe_timeout) begin
          rep  = lgs_pkg::REP_FAIL;
          done = 1'b1;
        end
      end
      if (done) begin
        s.probe_count = '0;
        if (state.probe_step == lgs_pkg::PROBE_ONE) begin
          s.laser_one  = 1'b0;
          s.laser_two  = 1'b1;
          s.probe_step = lgs_pkg::PROBE_TWO;
        end else begin
          // The end of the probe drops any byte that arrived meanwhile.
          s.laser_two  = 1'b0;
          s.probe_step = lgs_pkg::PROBE_IDLE;
          s.mailbox    = lgs_pkg::CMD_NONE;
        end
      end
      send = done;
    end else begin
      if (s.mailbox == lgs_pkg::CMD_TOGGLE_ONE) begin
        s.laser_one = ~s.laser_one;
        s.mailbox   = lgs_pkg::CMD_NONE;
      end else if (s.mailbox == lgs_pkg::CMD_TOGGLE_TWO) begin
        s.laser_two = ~s.laser_two;
        s.mailbox   = lgs_pkg::CMD_NONE;
      end else if (s.mailbox == lgs_pkg::CMD_CHECK) begin
        s.laser_one   = 1'b1;
        s.probe_count = '0;
        s.probe_step  = lgs_pkg::PROBE_ONE;
        stop          = 1'b1;
      end else if (s.mailbox == lgs_pkg::CMD_ARM) begin
        if (state.phase != lgs_pkg::PHASE_INACTIVE) begin
          s.laser_two = 1'b0;
        end else begin
          s.settle_count = cfg.boot_delay;
          stop           = (cfg.boot_delay != '0);
        end
        s.laser_one = 1'b1;
        s.phase     = lgs_pkg::PHASE_ARMED;
        s.mailbox   = lgs_pkg::CMD_NONE;
      end

      if (!stop) begin
        if (s.phase == lgs_pkg::PHASE_ARMED && item.sensor_one) begin
          s.phase        = lgs_pkg::PHASE_TIMING;
          s.laser_one    = 1'b0;
          s.laser_two    = 1'b1;
          s.settle_count = cfg.boot_delay;
          rep            = lgs_pkg::REP_START;
          send           = 1'b1;
        end else if (s.phase == lgs_pkg::PHASE_TIMING && item.sensor_two) begin
          s.phase        = lgs_pkg::PHASE_INACTIVE;
          s.laser_two    = 1'b0;
          s.settle_count = cfg.boot_delay;
          rep            = lgs_pkg::REP_FINISH;
          send           = 1'b1;
        end
      end
    end

    state_next          = s;
    result.laser_one_on = s.laser_one;
    result.laser_two_on = s.laser_two;
    result.tx_valid     = send;
    result.tx_byte      = send ? rep : lgs_pkg::REP_NONE;
    result.gate_phase   = s.phase;
  end

endmodule

`default_nettype wire

### design/light_gate_sequencer.sv
// Top level of the light gate sequencer: input register, tick logic, state
// and result register. Depends on lgs_pkg, lgs_cfg, lgs_step and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "light_gate_sequencer_defines.svh"

// Each input item is one tick: an optional command byte (rx_valid, rx_byte)
// and the two photosensor levels. Every accepted item produces exactly one
// result item holding the laser drive levels, an optional report byte
// (tx_valid, tx_byte) and the gate phase after that tick.
// Both item channels use valid/ready. An item is held in an input register,
// the tick logic runs on it and the result lands in the output register.
// One item per cycle is sustained: the input register passes its item on
// whenever the output register is empty or being read in the same cycle, and
// in_ready stays high in that case, so ticks go back to back.
// When the receiver stalls, the result waits in the output register, one more
// item waits in the input register, and then in_ready drops until out_ready
// returns. The sequencer state only advances when a tick moves into the
// output register, so stalls never change the sequence of results.
// The configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 is the check timeout, index 1 the boot delay, others are
// ignored. Write it only while no tick is in flight.
// Synchronous reset clears the state (lasers off, gate inactive, empty
// mailbox, no probe, no countdown), empties both registers and loads the
// configuration defaults of 100 and 10 ticks.

module light_gate_sequencer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Tick input channel.
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            rx_valid,
  input  wire lgs_pkg::byte_t                  rx_byte,
  input  wire logic                            sensor_one,
  input  wire logic                            sensor_two,
  // Result channel.
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 laser_one_on,
  output logic                                 laser_two_on,
  output logic                                 tx_valid,
  output lgs_pkg::byte_t                       tx_byte,
  output lgs_pkg::phase_t                      gate_phase,
  // Configuration write channel.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lgs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire lgs_pkg::count_t                 cfg_data
);

  lgs_pkg::cfg_t    cfg;
  lgs_pkg::item_t   item;
  logic             item_valid;
  lgs_pkg::state_t  state;
  lgs_pkg::state_t  state_next;
  lgs_pkg::result_t result_next;
  lgs_pkg::result_t result;
  logic             tick_advance;

  assign cfg_ready = 1'b1;

  lgs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held tick moves on when the output register is free or being drained.
  assign tick_advance = item_valid && (!out_valid || out_ready);
  assign in_ready     = !item_valid || tick_advance;

  // Input register: payload needs no reset, only the valid flag does.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.rx_valid   <= rx_valid;
      item.rx_byte    <= rx_byte;
      item.sensor_one <= sensor_one;
      item.sensor_two <= sensor_two;
    end
  end

  lgs_step u_step (
    .state      (state),
    .item       (item),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result_next)
  );

  // Sequencer state commits together with the result it produced.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (tick_advance) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_advance) begin
      result <= result_next;
    end
  end

  assign laser_one_on = result.laser_one_on;
  assign laser_two_on = result.laser_two_on;
  assign tx_valid     = result.tx_valid;
  assign tx_byte      = result.tx_byte;
  assign gate_phase   = result.gate_phase;

  // A result without a report carries a zero byte.
  `LGS_ASSERT(a_quiet_byte, !out_valid || tx_valid || tx_byte == lgs_pkg::REP_NONE)
  // The probe step never takes the unused code.
  `LGS_ASSERT(a_probe_code, state.probe_step == lgs_pkg::PROBE_IDLE ||
              state.probe_step == lgs_pkg::PROBE_ONE || state.probe_step == lgs_pkg::PROBE_TWO)
  // A running countdown only counts down, one per tick.
  `LGS_ASSERT_NEXT(a_settle_down, tick_advance && state.settle_count != '0,
                   state.settle_count == 10'($past(state.settle_count) - 10'd1))
  // Probing never moves the gate phase.
  `LGS_ASSERT_NEXT(a_probe_phase,
                   tick_advance && state.settle_count == '0 &&
                   state.probe_step != lgs_pkg::PROBE_IDLE,
                   state.phase == $past(state.phase))

endmodule

`default_nettype wire

### sim/light_gate_sequencer_test.sv
// Self-checking testbench for light_gate_sequencer: directed and random ticks,
// random idling on both channels, checked against a cycle-free tick predictor.
// Depends on lgs_pkg and the light_gate_sequencer RTL only.
`timescale 1ns / 1ps

module light_gate_sequencer_test;

  // The watchdog limit is far above the slowest legal run: about 1000 ticks,
  // each with a long sender gap and receiver stall, plus one long hold-off.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_OFF_CYCLES = 120;

  // Indexes that the block decodes as no register at all.
  localparam logic [lgs_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [lgs_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  // The scoreboard carries its own copy of the sequencer state and
  // configuration. Each accepted tick is run through it at once, and the
  // result it yields waits in order until the block offers its result.
  class tick_scoreboard;
    lgs_pkg::count_t  probe_limit;
    lgs_pkg::count_t  settle_delay;
    lgs_pkg::phase_t  gate_mode;
    logic             laser_one;
    logic             laser_two;
    lgs_pkg::byte_t   mailbox;
    lgs_pkg::step_t   probe_at;
    lgs_pkg::count_t  probe_ticks;
    lgs_pkg::count_t  settle_left;
    lgs_pkg::result_t pending_results[$];
    int               errors;

    function new();
      probe_limit  = lgs_pkg::PROBE_TIMEOUT_RESET;
      settle_delay = lgs_pkg::BOOT_DELAY_RESET;
      gate_mode    = lgs_pkg::PHASE_INACTIVE;
      laser_one    = 1'b0;
      laser_two    = 1'b0;
      mailbox      = lgs_pkg::CMD_NONE;
      probe_at     = lgs_pkg::PROBE_IDLE;
      probe_ticks  = '0;
      settle_left  = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [lgs_pkg::CFG_INDEX_W-1:0] index, lgs_pkg::count_t data);
      if (index == lgs_pkg::CFG_PROBE_TIMEOUT) begin
        probe_limit = data;
      end else if (index == lgs_pkg::CFG_BOOT_DELAY) begin
        settle_delay = data;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Advance the copy of the state by one tick and queue the result.
    function void note_tick(lgs_pkg::item_t tick);
      lgs_pkg::result_t want;
      logic             sensed;
      logic             done;
      logic             send;
      logic             stop;
      lgs_pkg::byte_t   report;
      send   = 1'b0;
      report = lgs_pkg::REP_NONE;
      if (tick.rx_valid) begin
        mailbox = tick.rx_byte;
      end
      if (settle_left != 0) begin
        // A settle wait swallows the whole tick.
        settle_left = settle_left - 1'b1;
      end else if (probe_at != lgs_pkg::PROBE_IDLE) begin
        sensed = (probe_at == lgs_pkg::PROBE_ONE) ? tick.sensor_one : tick.sensor_two;
        done   = 1'b1;
        if (probe_limit == 0) begin
          // A zero timeout fails the probe without reading the sensor.
          report = lgs_pkg::REP_FAIL;
        end else if (!sensed) begin
          report = lgs_pkg::REP_PASS;
        end else begin
          probe_ticks = probe_ticks + 1'b1;
          if (probe_ticks >= probe_limit) begin
            report = lgs_pkg::REP_FAIL;
          end else begin
            done = 1'b0;
          end
        end
        if (done) begin
          send        = 1'b1;
          probe_ticks = '0;
          if (probe_at == lgs_pkg::PROBE_ONE) begin
            laser_one = 1'b0;
            laser_two = 1'b1;
            probe_at  = lgs_pkg::PROBE_TWO;
          end else begin
            // The end of a probe drops whatever byte came in meanwhile.
            laser_two = 1'b0;
            probe_at  = lgs_pkg::PROBE_IDLE;
            mailbox   = lgs_pkg::CMD_NONE;
          end
        end
      end else begin
        stop = 1'b0;
        case (mailbox)
          lgs_pkg::CMD_TOGGLE_ONE: begin
            laser_one = ~laser_one;
            mailbox   = lgs_pkg::CMD_NONE;
          end
          lgs_pkg::CMD_TOGGLE_TWO: begin
            laser_two = ~laser_two;
            mailbox   = lgs_pkg::CMD_NONE;
          end
          lgs_pkg::CMD_CHECK: begin
            laser_one   = 1'b1;
            probe_ticks = '0;
            probe_at    = lgs_pkg::PROBE_ONE;
            stop        = 1'b1;
          end
          lgs_pkg::CMD_ARM: begin
            if (gate_mode != lgs_pkg::PHASE_INACTIVE) begin
              laser_one = 1'b1;
              laser_two = 1'b0;
            end else begin
              laser_one   = 1'b1;
              settle_left = settle_delay;
              stop        = (settle_delay != 0);
            end
            gate_mode = lgs_pkg::PHASE_ARMED;
            mailbox   = lgs_pkg::CMD_NONE;
          end
          default: begin
          end
        endcase
        if (!stop) begin
          if (gate_mode == lgs_pkg::PHASE_ARMED && tick.sensor_one) begin
            gate_mode   = lgs_pkg::PHASE_TIMING;
            report      = lgs_pkg::REP_START;
            send        = 1'b1;
            laser_one   = 1'b0;
            laser_two   = 1'b1;
            settle_left = settle_delay;
          end else if (gate_mode == lgs_pkg::PHASE_TIMING && tick.sensor_two) begin
            gate_mode   = lgs_pkg::PHASE_INACTIVE;
            report      = lgs_pkg::REP_FINISH;
            send        = 1'b1;
            laser_two   = 1'b0;
            settle_left = settle_delay;
          end
        end
      end
      want.laser_one_on = laser_one;
      want.laser_two_on = laser_two;
      want.tx_valid     = send;
      want.tx_byte      = send ? report : lgs_pkg::REP_NONE;
      want.gate_phase   = gate_mode;
      pending_results.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(lgs_pkg::result_t got);
      lgs_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("laser_one_on", want.laser_one_on, got.laser_one_on);
      compare_field("laser_two_on", want.laser_two_on, got.laser_two_on);
      compare_field("tx_valid", want.tx_valid, got.tx_valid);
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("gate_phase", want.gate_phase, got.gate_phase);
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  logic                            rx_valid;
  lgs_pkg::byte_t                  rx_byte;
  logic                            sensor_one;
  logic                            sensor_two;
  logic                            out_valid;
  logic                            out_ready;
  logic                            laser_one_on;
  logic                            laser_two_on;
  logic                            tx_valid;
  lgs_pkg::byte_t                  tx_byte;
  lgs_pkg::phase_t                 gate_phase;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [lgs_pkg::CFG_INDEX_W-1:0] cfg_index;
  lgs_pkg::count_t                 cfg_data;

  tick_scoreboard sb;
  lgs_pkg::item_t tick_queue[$];
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  bit             hold_request;
  int unsigned    cycle_count;

  light_gate_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_valid     (rx_valid),
    .rx_byte      (rx_byte),
    .sensor_one   (sensor_one),
    .sensor_two   (sensor_two),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .laser_one_on (laser_one_on),
    .laser_two_on (laser_two_on),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .gate_phase   (gate_phase),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 8 ns clock, starting low so that the first rising edge comes at 4 ns.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog. A run that has not ended by the limit is a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Result side. Every edge first checks an item taken at that edge, then
  // decides whether to stall next cycle. A hold-off request from the main
  // process is counted down here, one cycle at a time, with ready kept low.
  initial begin
    int unsigned      hold_left;
    lgs_pkg::result_t got;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        got.laser_one_on = laser_one_on;
        got.laser_two_on = laser_two_on;
        got.tx_valid     = tx_valid;
        got.tx_byte      = tx_byte;
        got.gate_phase   = gate_phase;
        sb.check_result(got);
      end
      if (hold_request) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic add_tick(logic valid, lgs_pkg::byte_t data, logic s_one, logic s_two);
    lgs_pkg::item_t tick;
    tick.rx_valid   = valid;
    tick.rx_byte    = data;
    tick.sensor_one = s_one;
    tick.sensor_two = s_two;
    tick_queue.push_back(tick);
  endtask

  // Random ticks. Most received bytes are real commands so that arming,
  // gate events and probes happen often; the rest are empty or arbitrary
  // bytes. The sensor bias decides how quickly probes and gate events resolve.
  function automatic lgs_pkg::item_t random_tick(int unsigned sensor_pct);
    lgs_pkg::item_t tick;
    int unsigned    pick;
    pick            = $urandom_range(99);
    tick.rx_valid   = ($urandom_range(99) < 20);
    if (pick < 20) begin
      tick.rx_byte = lgs_pkg::CMD_TOGGLE_ONE;
    end else if (pick < 40) begin
      tick.rx_byte = lgs_pkg::CMD_TOGGLE_TWO;
    end else if (pick < 55) begin
      tick.rx_byte = lgs_pkg::CMD_CHECK;
    end else if (pick < 80) begin
      tick.rx_byte = lgs_pkg::CMD_ARM;
    end else if (pick < 88) begin
      tick.rx_byte = lgs_pkg::CMD_NONE;
    end else begin
      tick.rx_byte = lgs_pkg::byte_t'($urandom_range(255));
    end
    tick.sensor_one = ($urandom_range(99) < sensor_pct);
    tick.sensor_two = ($urandom_range(99) < sensor_pct);
    return tick;
  endfunction

  // Offer every queued tick on the input channel. The item on the port stays
  // put until it is taken; only then may the next one, or a gap, follow.
  task automatic drive_ticks();
    lgs_pkg::item_t cur;
    bit             offering;
    offering = 1'b0;
    while (tick_queue.size() != 0 || offering) begin
      @(posedge clk);
      if (offering && in_ready === 1'b1) begin
        sb.note_tick(cur);
        offering = 1'b0;
      end
      if (!offering && tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur        = tick_queue.pop_front();
        offering   = 1'b1;
        rx_valid   <= cur.rx_valid;
        rx_byte    <= cur.rx_byte;
        sensor_one <= cur.sensor_one;
        sensor_two <= cur.sensor_two;
      end
      in_valid <= offering;
    end
  endtask

  // Wait until every result is back, then idle on the clock so that nothing in
  // the two-stage pipe is in flight before the registers change.
  task automatic wait_idle();
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Write both registers and one unused index, back to back. Valid stays high
  // between the writes and drops once after the last one.
  task automatic program_regs(lgs_pkg::count_t timeout, lgs_pkg::count_t delay);
    logic [lgs_pkg::CFG_INDEX_W-1:0] idx[3];
    lgs_pkg::count_t                 val[3];
    idx[0] = lgs_pkg::CFG_PROBE_TIMEOUT;
    val[0] = timeout;
    idx[1] = lgs_pkg::CFG_BOOT_DELAY;
    val[1] = delay;
    idx[2] = $urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO;
    val[2] = lgs_pkg::count_t'($urandom_range(1023));
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do begin
        @(posedge clk);
      end while (cfg_ready !== 1'b1);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned timeouts[8];
    int unsigned delays[8];
    int unsigned counts[8];
    sb = new();
    timeouts = '{3, 1, 1023, 0, 5, 2, 7, 100};
    delays   = '{2, 1, 1023, 0, 3, 0, 1, 10};
    counts   = '{150, 130, 60, 130, 150, 130, 130, 100};

    // Every input is known from time zero; reset is asserted before the first clock edge.
    rst            = 1'b1;
    in_valid       = 1'b0;
    rx_valid       = 1'b0;
    rx_byte        = lgs_pkg::CMD_NONE;
    sensor_one     = 1'b0;
    sensor_two     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = lgs_pkg::CFG_PROBE_TIMEOUT;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks under the reset configuration: both toggles, sensors
    // ignored while inactive, an unknown byte and an all-ones byte without
    // rx_valid, a zero byte, and a full probe that passes on both lasers
    // while an arm byte arriving during the probe gets dropped.
    add_tick(1'b1, lgs_pkg::CMD_TOGGLE_ONE, 1'b0, 1'b0);
    add_tick(1'b1, lgs_pkg::CMD_TOGGLE_TWO, 1'b0, 1'b0);
    add_tick(1'b1, lgs_pkg::CMD_TOGGLE_ONE, 1'b1, 1'b1);
    add_tick(1'b1, lgs_pkg::CMD_TOGGLE_TWO, 1'b0, 1'b0);
    add_tick(1'b1, 8'hFF, 1'b1, 1'b1);
    add_tick(1'b0, 8'hFF, 1'b0, 1'b0);
    add_tick(1'b1, lgs_pkg::CMD_NONE, 1'b0, 1'b0);
    add_tick(1'b1, lgs_pkg::CMD_CHECK, 1'b0, 1'b0);
    add_tick(1'b0, lgs_pkg::CMD_NONE, 1'b0, 1'b1);
    add_tick(1'b1, lgs_pkg::CMD_ARM, 1'b1, 1'b0);
    drive_ticks();
    wait_idle();

    // Zero timeout and zero delay: the probe fails at once on both lasers,
    // arming from inactive needs no settle wait, and a re-arm is followed
    // by the start event in the same tick.
    program_regs(lgs_pkg::count_t'(0), lgs_pkg::count_t'(0));
    add_tick(1'b1, lgs_pkg::CMD_CHECK, 1'b1, 1'b1);
    add_tick(1'b0, lgs_pkg::CMD_NONE, 1'b1, 1'b1);
    add_tick(1'b0, lgs_pkg::CMD_NONE, 1'b1, 1'b1);
    add_tick(1'b1, lgs_pkg::CMD_ARM, 1'b0, 1'b0);
    add_tick(1'b1, lgs_pkg::CMD_ARM, 1'b1, 1'b0);
    add_tick(1'b0, lgs_pkg::CMD_NONE, 1'b1, 1'b1);
    drive_ticks();
    wait_idle();

    // Short waits: settle ticks after arming and after the start event, a
    // byte held in the mailbox through a wait, a re-arm from the timing
    // phase, and a probe that times out on laser one.
    program_regs(lgs_pkg::count_t'(2), lgs_pkg::count_t'(1));
    add_tick(1'b1, lgs_pkg::CMD_ARM, 1'b1, 1'b1);
    add_tick(1'b0, lgs_pkg::CMD_NONE, 1'b1, 1'b1);
    add_tick(1'b0, lgs_pkg::CMD_NONE, 1'b1, 1'b0);
    add_tick(1'b1, lgs_pkg::CMD_ARM, 1'b0, 1'b1);
    add_tick(1'b0, lgs_pkg::CMD_NONE, 1'b0, 1'b0);
    add_tick(1'b1, lgs_pkg::CMD_CHECK, 1'b0, 1'b0);
    add_tick(1'b0, lgs_pkg::CMD_NONE, 1'b1, 1'b1);
    add_tick(1'b0, lgs_pkg::CMD_NONE, 1'b1, 1'b1);
    add_tick(1'b0, lgs_pkg::CMD_NONE, 1'b0, 1'b0);
    drive_ticks();
    wait_idle();

    // Random phases. Each one gets its own register setting, the extremes
    // among them, and the idling pattern rotates through none, sender only,
    // receiver only, and both. One phase with a busy sender also gets a long
    // receiver hold-off so that both pipeline registers fill and in_ready
    // drops.
    for (int p = 0; p < 8; p++) begin
      program_regs(lgs_pkg::count_t'(timeouts[p]), lgs_pkg::count_t'(delays[p]));
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct  = 33;
          recv_stall_pct = 33;
        end
      endcase
      for (int n = 0; n < counts[p]; n++) begin
        tick_queue.push_back(random_tick((p % 2 == 0) ? 20 : 45));
      end
      if (p == 4) begin
        hold_request = 1'b1;
      end
      drive_ticks();
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/lgs_pkg.sv
design/lgs_cfg.sv
design/lgs_step.sv
design/light_gate_sequencer.sv
sim/light_gate_sequencer_test.sv
